// ===== hw/rtl/disk_request_queue_retry_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the disk request queue
// Shared implication checks, sampled on the rising clock edge and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef DISK_REQUEST_QUEUE_RETRY_CORE_ASSERT_SVH
`define DISK_REQUEST_QUEUE_RETRY_CORE_ASSERT_SVH

// Same-cycle implication.
`define DRQR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("drqr assertion failed");

// Next-cycle implication.
`define DRQR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("drqr assertion failed");

`endif

// ===== hw/rtl/drqr_pkg.sv =====
// ----------------------------------------------------------------------------
// drqr_pkg
// Types, codes and helper functions shared by the disk request queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package drqr_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int OUTQ_DEPTH  = 4;
	localparam int OPTR_W      = $clog2(OUTQ_DEPTH);
	localparam int OCNT_W      = $clog2(OUTQ_DEPTH + 1);

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [15:0] DISK_BLOCKS_RESET = 16'd1024;
	localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd10;

	// Controller control word bits.
	localparam logic [7:0] CTL_IENB  = 8'h40;
	localparam logic [7:0] CTL_READ  = 8'h04;
	localparam logic [7:0] CTL_WRITE = 8'h02;
	localparam logic [7:0] CTL_GO    = 8'h01;

	localparam logic CMD_SUBMIT   = 1'b0;
	localparam logic CMD_COMPLETE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_DISK_BLOCKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 2'd1;

	typedef enum logic [1:0] {
		OP_SUBMIT   = 2'd0,
		OP_REJECT   = 2'd1,
		OP_COMPLETE = 2'd2
	} op_t;

	typedef enum logic {
		KIND_ISSUE  = 1'b0,
		KIND_FINISH = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_RANGE  = 2'd1,
		ST_FAILED = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  tag;
		logic [15:0] block;
		logic        is_read;
		logic [15:0] addr;
		logic [15:0] count;
	} req_t;

	typedef struct packed {
		op_t  op;
		req_t req;
		logic dev_err;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tag;
		status_t     status;
		logic [7:0]  ctl;
		logic [15:0] bus_addr;
		logic [15:0] xfer_count;
		logic [15:0] dal;
		logic [7:0]  dae;
		logic        last;
	} res_t;

	typedef struct packed {
		logic push0;
		logic push1;
		res_t r0;
		res_t r1;
	} res_push_t;

	function automatic logic [QPTR_W-1:0] qptr_inc(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + QPTR_W'(1);
		end
		return n;
	endfunction

	function automatic res_t make_issue(input req_t q, input logic lst);
		res_t r;
		r.kind       = KIND_ISSUE;
		r.tag        = q.tag;
		r.status     = ST_OK;
		r.ctl        = CTL_IENB | CTL_GO | (q.is_read ? CTL_READ : CTL_WRITE);
		r.bus_addr   = q.addr;
		r.xfer_count = q.count;
		r.dal        = {q.block[7:0], 8'h00};
		r.dae        = q.block[15:8];
		r.last       = lst;
		return r;
	endfunction

	function automatic res_t make_finish(input logic [7:0] tag, input status_t st,
			input logic lst);
		res_t r;
		r            = '0;
		r.kind       = KIND_FINISH;
		r.tag        = tag;
		r.status     = st;
		r.last       = lst;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/drqr_front.sv =====
// ----------------------------------------------------------------------------
// drqr_front
// Accepts input words, checks the block range and holds them in a two-entry
// queue until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module drqr_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic                command,
	input  wire logic [7:0]          request_tag,
	input  wire logic [15:0]         block_number,
	input  wire logic                is_read,
	input  wire logic [15:0]         buffer_address,
	input  wire logic [15:0]         word_count,
	input  wire logic                device_error,
	input  wire logic [15:0]         disk_blocks,
	output logic                     op_valid,
	output drqr_pkg::item_t          op_item,
	input  wire logic                op_pop
);

	drqr_pkg::item_t slot_q [2];
	logic            head_q;
	logic [1:0]      cnt_q;
	drqr_pkg::item_t in_item;
	logic            wr_en;
	logic            rd_en;
	logic            wr_idx;

	always_comb begin
		in_item.req.tag     = request_tag;
		in_item.req.block   = block_number;
		in_item.req.is_read = is_read;
		in_item.req.addr    = buffer_address;
		in_item.req.count   = word_count;
		in_item.dev_err     = device_error;
		if (command == drqr_pkg::CMD_COMPLETE) begin
			in_item.op = drqr_pkg::OP_COMPLETE;
		end else if (block_number >= disk_blocks) begin
			in_item.op = drqr_pkg::OP_REJECT;
		end else begin
			in_item.op = drqr_pkg::OP_SUBMIT;
		end
	end

	assign full     = (cnt_q == 2'd2);
	assign op_valid = (cnt_q != 2'd0);
	assign op_item  = slot_q[head_q];
	assign wr_en    = push && !full;
	assign rd_en    = op_pop && op_valid;
	assign wr_idx   = head_q ^ cnt_q[0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_idx] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (rd_en) begin
				head_q <= ~head_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/drqr_back.sv =====
// ----------------------------------------------------------------------------
// drqr_back
// Request queue, drive state and retry counter. Carries out one word a cycle
// while the output queue has room for two results, and hands up to two results to it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "disk_request_queue_retry_core_assert.svh"

module drqr_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                op_valid,
	input  wire drqr_pkg::item_t     op_item,
	output logic                     op_pop,
	input  wire logic                space_ok,
	input  wire logic [3:0]          retry_limit,
	output drqr_pkg::res_push_t      res_out
);

	drqr_pkg::req_t                  fifo_q [drqr_pkg::QUEUE_DEPTH];
	logic [drqr_pkg::QPTR_W-1:0]     head_q;
	logic [drqr_pkg::QPTR_W-1:0]     tail_q;
	logic [drqr_pkg::QCNT_W-1:0]     cnt_q;
	logic                            active_q;
	logic [3:0]                      tally_q;
	drqr_pkg::req_t                  cur_q;

	logic [drqr_pkg::QPTR_W-1:0]     head_nxt;
	logic [drqr_pkg::QPTR_W-1:0]     tail_d;
	logic [drqr_pkg::QPTR_W-1:0]     head_d;
	logic [drqr_pkg::QCNT_W-1:0]     cnt_d;
	logic                            active_d;
	logic [3:0]                      tally_d;
	drqr_pkg::req_t                  cur_d;
	drqr_pkg::req_t                  next_req;
	logic                            fifo_we;
	logic [4:0]                      tally_inc;
	logic                            fire;

	assign fire      = op_valid && space_ok;
	assign op_pop    = fire;
	assign head_nxt  = drqr_pkg::qptr_inc(head_q);
	assign next_req  = fifo_q[head_nxt];
	assign tally_inc = {1'b0, tally_q} + 5'd1;

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		active_d = active_q;
		tally_d  = tally_q;
		cur_d    = cur_q;
		fifo_we  = 1'b0;
		res_out  = '0;
		if (fire) begin
			case (op_item.op)
				drqr_pkg::OP_REJECT: begin
					res_out.push0 = 1'b1;
					res_out.r0    = drqr_pkg::make_finish(op_item.req.tag,
						drqr_pkg::ST_RANGE, 1'b1);
				end
				drqr_pkg::OP_SUBMIT: begin
					if (cnt_q == drqr_pkg::QCNT_W'(drqr_pkg::QUEUE_DEPTH)) begin
						res_out.push0 = 1'b1;
						res_out.r0    = drqr_pkg::make_finish(op_item.req.tag,
							drqr_pkg::ST_FULL, 1'b1);
					end else begin
						fifo_we = 1'b1;
						tail_d  = drqr_pkg::qptr_inc(tail_q);
						cnt_d   = cnt_q + drqr_pkg::QCNT_W'(1);
						// An idle drive always has an empty queue, so the new
						// request is the head and goes out at once.
						if (!active_q) begin
							active_d      = 1'b1;
							cur_d         = op_item.req;
							res_out.push0 = 1'b1;
							res_out.r0    = drqr_pkg::make_issue(op_item.req, 1'b1);
						end
					end
				end
				drqr_pkg::OP_COMPLETE: begin
					active_d = 1'b0;
					if (active_q && cnt_q != '0) begin
						if (op_item.dev_err && tally_inc <= {1'b0, retry_limit}) begin
							tally_d       = tally_inc[3:0];
							active_d      = 1'b1;
							res_out.push0 = 1'b1;
							res_out.r0    = drqr_pkg::make_issue(cur_q, 1'b1);
						end else begin
							tally_d       = 4'd0;
							head_d        = head_nxt;
							cnt_d         = cnt_q - drqr_pkg::QCNT_W'(1);
							res_out.push0 = 1'b1;
							res_out.r0    = drqr_pkg::make_finish(cur_q.tag,
								op_item.dev_err ? drqr_pkg::ST_FAILED : drqr_pkg::ST_OK,
								cnt_q == drqr_pkg::QCNT_W'(1));
							if (cnt_q != drqr_pkg::QCNT_W'(1)) begin
								active_d      = 1'b1;
								cur_d         = next_req;
								res_out.push1 = 1'b1;
								res_out.r1    = drqr_pkg::make_issue(next_req, 1'b1);
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_we) begin
			fifo_q[tail_q] <= op_item.req;
		end
		cur_q <= cur_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			cnt_q    <= '0;
			active_q <= 1'b0;
			tally_q  <= 4'd0;
		end else begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			cnt_q    <= cnt_d;
			active_q <= active_d;
			tally_q  <= tally_d;
		end
	end

	`DRQR_ASSERT_IMPL(a_active_has_req, clk, arst_n, active_q, cnt_q != '0)
	`DRQR_ASSERT_IMPL(a_idle_no_tally, clk, arst_n, !active_q, tally_q == 4'd0)
	`DRQR_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1,
		cnt_q <= drqr_pkg::QCNT_W'(drqr_pkg::QUEUE_DEPTH))

endmodule

`default_nettype wire

// ===== hw/rtl/drqr_outq.sv =====
// ----------------------------------------------------------------------------
// drqr_outq
// Result queue: takes up to two results a cycle from the back end and
// delivers one word a cycle to the consumer while it holds results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "disk_request_queue_retry_core_assert.svh"

module drqr_outq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire drqr_pkg::res_push_t res_in,
	output logic                     space_ok,
	output logic                     empty,
	input  wire logic                pop,
	output drqr_pkg::res_t           res_head
);

	drqr_pkg::res_t              slot_q [drqr_pkg::OUTQ_DEPTH];
	logic [drqr_pkg::OPTR_W-1:0] head_q;
	logic [drqr_pkg::OPTR_W-1:0] tail_q;
	logic [drqr_pkg::OCNT_W-1:0] cnt_q;
	logic [drqr_pkg::OPTR_W-1:0] tail_p1;
	logic                        rd_en;
	logic [drqr_pkg::OCNT_W-1:0] n_push;

	assign empty    = (cnt_q == '0);
	assign space_ok = (cnt_q <= drqr_pkg::OCNT_W'(drqr_pkg::OUTQ_DEPTH - 2));
	assign res_head = slot_q[head_q];
	assign rd_en    = pop && !empty;
	assign tail_p1  = tail_q + drqr_pkg::OPTR_W'(1);
	assign n_push   = drqr_pkg::OCNT_W'(res_in.push0) + drqr_pkg::OCNT_W'(res_in.push1);

	always_ff @(posedge clk) begin
		if (res_in.push0) begin
			slot_q[tail_q] <= res_in.r0;
		end
		if (res_in.push1) begin
			slot_q[tail_p1] <= res_in.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (rd_en) begin
				head_q <= head_q + drqr_pkg::OPTR_W'(1);
			end
			tail_q <= tail_q + n_push[drqr_pkg::OPTR_W-1:0];
			cnt_q  <= cnt_q + n_push - drqr_pkg::OCNT_W'(rd_en);
		end
	end

	`DRQR_ASSERT_IMPL(a_push_order, clk, arst_n, res_in.push1, res_in.push0)
	`DRQR_ASSERT_IMPL(a_no_overflow, clk, arst_n, res_in.push0, space_ok)
	`DRQR_ASSERT_NEXT(a_push_shows, clk, arst_n, res_in.push0, !empty)

endmodule

`default_nettype wire

// ===== hw/rtl/disk_request_queue_retry_core.sv =====
// Results are written into the result queue and show on the result ports at its head.
// Throughput: one input word per cycle while full is low; the back end takes a word
// when the result queue has room for two, and the result side drains one word a cycle.
// Reset: asynchronous, active low; clears queues, drive state and retry count, and
// loads disk_blocks with 1024 and retry_limit with 10.
// ----------------------------------------------------------------------------
// disk_request_queue_retry_core
// Disk request queue with retry: front classifier, request queue engine and
// result queue, plus the two configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_request_queue_retry_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic                              command,
	input  wire logic [7:0]                        request_tag,
	input  wire logic [15:0]                       block_number,
	input  wire logic                              is_read,
	input  wire logic [15:0]                       buffer_address,
	input  wire logic [15:0]                       word_count,
	input  wire logic                              device_error,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic                                   kind,
	output logic [7:0]                             result_tag,
	output logic [1:0]                             status,
	output logic [7:0]                             control_word,
	output logic [15:0]                            bus_address,
	output logic [15:0]                            transfer_count,
	output logic [15:0]                            disk_address_low,
	output logic [7:0]                             disk_address_ext,
	output logic                                   last,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [drqr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [drqr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [15:0]         disk_blocks_q;
	logic [3:0]          retry_limit_q;
	logic                op_valid;
	drqr_pkg::item_t     op_item;
	logic                op_pop;
	logic                space_ok;
	drqr_pkg::res_push_t res_push;
	drqr_pkg::res_t      res_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_blocks_q <= drqr_pkg::DISK_BLOCKS_RESET;
			retry_limit_q <= drqr_pkg::RETRY_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				drqr_pkg::REG_DISK_BLOCKS: disk_blocks_q <= cfg_data[15:0];
				drqr_pkg::REG_RETRY_LIMIT: retry_limit_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	drqr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.command        (command),
		.request_tag    (request_tag),
		.block_number   (block_number),
		.is_read        (is_read),
		.buffer_address (buffer_address),
		.word_count     (word_count),
		.device_error   (device_error),
		.disk_blocks    (disk_blocks_q),
		.op_valid       (op_valid),
		.op_item        (op_item),
		.op_pop         (op_pop)
	);

	drqr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (op_valid),
		.op_item     (op_item),
		.op_pop      (op_pop),
		.space_ok    (space_ok),
		.retry_limit (retry_limit_q),
		.res_out     (res_push)
	);

	drqr_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_in   (res_push),
		.space_ok (space_ok),
		.empty    (empty),
		.pop      (pop),
		.res_head (res_head)
	);

	assign kind             = res_head.kind;
	assign result_tag       = res_head.tag;
	assign status           = res_head.status;
	assign control_word     = res_head.ctl;
	assign bus_address      = res_head.bus_addr;
	assign transfer_count   = res_head.xfer_count;
	assign disk_address_low = res_head.dal;
	assign disk_address_ext = res_head.dae;
	assign last             = res_head.last;

endmodule

`default_nettype wire
